// ----- hdl/dlf_pkg.sv -----
// ----------------------------------------------------------------------------
// dlf_pkg
// shared constants, types, codes and the sigmoid table for the dense layer
// ----------------------------------------------------------------------------
package dlf_pkg;

   localparam int MAX_INPUTS  = 64;
   localparam int MAX_OUTPUTS = 16;
   localparam int IN_IDX_W    = $clog2(MAX_INPUTS);
   localparam int OUT_IDX_W   = $clog2(MAX_OUTPUTS);
   localparam int WADDR_W     = IN_IDX_W + OUT_IDX_W;
   localparam int DATA_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = 40;
   localparam int FRAC_W      = 8;

   localparam int CFG_IN_W    = 7;
   localparam int CFG_OUT_W   = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SIZE = 2'd2;

   // item kinds carried on tuser
   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_INPUT  = 2'd2
   } dlf_cmd_code_type;

   localparam logic CSR_ACT_RELU    = 1'b0;
   localparam logic CSR_ACT_SIGMOID = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic                 wr_weight;
      logic                 wr_bias;
      logic                 wr_input;
      logic                 acc_init;
      logic                 issue;
      logic                 round;
      logic                 load;
      logic                 final_res;
      logic                 sigmoid;
      logic [IN_IDX_W-1:0]  rd_in;
      logic [OUT_IDX_W-1:0] rd_out;
   } dlf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } dlf_stat_type;

   // 256*sigmoid(-(j+0.5)/16), rounded
   localparam logic [6:0] SIG_LOW [128] = '{
      7'd126, 7'd122, 7'd118, 7'd114, 7'd110, 7'd106, 7'd102, 7'd99, 7'd95, 7'd91,
      7'd87, 7'd84, 7'd80, 7'd77, 7'd74, 7'd70, 7'd67, 7'd64, 7'd61, 7'd58,
      7'd56, 7'd53, 7'd50, 7'd48, 7'd46, 7'd43, 7'd41, 7'd39, 7'd37, 7'd35,
      7'd33, 7'd31, 7'd30, 7'd28, 7'd27, 7'd25, 7'd24, 7'd22, 7'd21, 7'd20,
      7'd19, 7'd18, 7'd17, 7'd16, 7'd15, 7'd14, 7'd13, 7'd13, 7'd12, 7'd11,
      7'd10, 7'd10, 7'd9, 7'd9, 7'd8, 7'd8, 7'd7, 7'd7, 7'd6, 7'd6,
      7'd6, 7'd5, 7'd5, 7'd5, 7'd4, 7'd4, 7'd4, 7'd4, 7'd3, 7'd3,
      7'd3, 7'd3, 7'd3, 7'd3, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd2,
      7'd2, 7'd2, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
      7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
   };

   // table sigmoid over z clamped to [-8, 8) in 1/16 steps
   function automatic logic signed [DATA_W-1:0] sigmoid_q88(input logic signed [DATA_W-1:0] z);
      logic [7:0] k;
      logic [6:0] t;
      logic signed [DATA_W-1:0] r;
      if (z < -16'sd2048) begin
         k = 8'd0;
      end else if (z > 16'sd2047) begin
         k = 8'd255;
      end else begin
         // (z + 2048) >> 4 for z in range
         k = {~z[11], z[10:4]};
      end
      if (!k[7]) begin
         t = SIG_LOW[~k[6:0]];
         r = $signed({9'd0, t});
      end else begin
         t = SIG_LOW[k[6:0]];
         r = 16'sd256 - $signed({9'd0, t});
      end
      return r;
   endfunction

endpackage

// ----- hdl/dlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlf_ctrl
// config registers and the sequencer for loads and layer runs
// ----------------------------------------------------------------------------
module dlf_ctrl
   import dlf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   output dlf_cmd_type           cmd,
   input  dlf_stat_type          stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_ISSUE,
      ST_DRAIN,
      ST_ROUND,
      ST_LOAD
   } state_type;

   state_type              state_ff, state_in;
   logic                   act_mode_ff;
   logic [CFG_IN_W-1:0]    in_size_ff;
   logic [CFG_OUT_W-1:0]   out_size_ff;
   logic [IN_IDX_W-1:0]    i_ff, i_in;
   logic [OUT_IDX_W-1:0]   o_ff, o_in;
   logic [IN_IDX_W-1:0]    n_in_m1_ff, n_in_m1_in;
   logic [OUT_IDX_W-1:0]   n_out_m1_ff, n_out_m1_in;
   logic                   accept;
   logic                   start;
   logic                   last_neuron;

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign start       = accept && (req_tuser == CMD_INPUT) && req_tlast;
   assign last_neuron = (o_ff == n_out_m1_ff);

   // clamp the size registers into the store ranges
   always_comb begin
      if (in_size_ff == '0) begin
         n_in_m1_in = '0;
      end else if (in_size_ff > CFG_IN_W'(MAX_INPUTS)) begin
         n_in_m1_in = IN_IDX_W'(MAX_INPUTS - 1);
      end else begin
         n_in_m1_in = IN_IDX_W'(in_size_ff - CFG_IN_W'(1));
      end
      if (out_size_ff == '0) begin
         n_out_m1_in = '0;
      end else if (out_size_ff > CFG_OUT_W'(MAX_OUTPUTS)) begin
         n_out_m1_in = OUT_IDX_W'(MAX_OUTPUTS - 1);
      end else begin
         n_out_m1_in = OUT_IDX_W'(out_size_ff - CFG_OUT_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      o_in     = o_ff;
      cmd           = '0;
      cmd.rd_in     = i_ff;
      cmd.rd_out    = o_ff;
      cmd.sigmoid   = (act_mode_ff == CSR_ACT_SIGMOID);
      cmd.final_res = last_neuron;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.wr_weight = accept && (req_tuser == CMD_WEIGHT);
            cmd.wr_bias   = accept && (req_tuser == CMD_BIAS);
            cmd.wr_input  = accept && (req_tuser == CMD_INPUT);
            if (start) begin
               o_in     = '0;
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            cmd.acc_init = 1'b1;
            i_in         = '0;
            state_in     = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (i_ff == n_in_m1_ff) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + IN_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               if (last_neuron) begin
                  state_in = ST_IDLE;
               end else begin
                  o_in     = o_ff + OUT_IDX_W'(1);
                  state_in = ST_BIAS;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         act_mode_ff <= CSR_ACT_RELU;
         in_size_ff  <= CFG_IN_W'(64);
         out_size_ff <= CFG_OUT_W'(16);
         i_ff        <= '0;
         o_ff        <= '0;
         n_in_m1_ff  <= '0;
         n_out_m1_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         o_ff     <= o_in;
         if (start) begin
            n_in_m1_ff  <= n_in_m1_in;
            n_out_m1_ff <= n_out_m1_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ACT_MODE:    act_mode_ff <= csr_wdata[0];
               CSR_INPUT_SIZE:  in_size_ff  <= csr_wdata[CFG_IN_W-1:0];
               CSR_OUTPUT_SIZE: out_size_ff <= csr_wdata[CFG_OUT_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- hdl/dlf_datapath.sv -----
// ----------------------------------------------------------------------------
// dlf_datapath
// weight, bias and input stores, multiply-accumulate, rounding, activation
// ----------------------------------------------------------------------------
module dlf_datapath
   import dlf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dlf_cmd_type              cmd,
   output dlf_stat_type             stat,
   input  logic [IN_IDX_W-1:0]      wr_in_index,
   input  logic [OUT_IDX_W-1:0]     wr_out_index,
   input  logic signed [DATA_W-1:0] wr_value,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [OUT_IDX_W-1:0]     rsp_neuron,
   output logic signed [DATA_W-1:0] rsp_activation,
   output logic                     rsp_final
);

   logic signed [DATA_W-1:0] w_mem [MAX_INPUTS*MAX_OUTPUTS];
   logic signed [DATA_W-1:0] x_mem [MAX_INPUTS];
   logic signed [DATA_W-1:0] bias_ff [MAX_OUTPUTS];

   logic signed [DATA_W-1:0] w_q_ff, x_q_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0] z_ff;
   logic                     rd_v_ff, mul_v_ff;
   logic                     out_v_ff;
   logic [OUT_IDX_W-1:0]     neuron_ff;
   logic signed [DATA_W-1:0] act_ff;
   logic                     final_ff;

   logic signed [ACC_W-1:0]        rnd;
   logic signed [ACC_W-FRAC_W-1:0] zq;
   logic signed [DATA_W-1:0]       z_sat;
   logic signed [DATA_W-1:0]       act_in;

   // stores, written from load items and read one entry per issue
   always_ff @(posedge clock) begin
      if (cmd.wr_weight) begin
         w_mem[{wr_in_index, wr_out_index}] <= wr_value;
      end
      if (cmd.wr_input) begin
         x_mem[wr_in_index] <= wr_value;
      end
      if (cmd.issue) begin
         w_q_ff <= w_mem[{cmd.rd_in, cmd.rd_out}];
         x_q_ff <= x_mem[cmd.rd_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < MAX_OUTPUTS; b++) begin
            bias_ff[b] <= '0;
         end
      end else if (cmd.wr_bias) begin
         bias_ff[wr_out_index] <= wr_value;
      end
   end

   // round half up to q8.8 then saturate
   always_comb begin
      rnd = acc_ff + ACC_W'(128);
      zq  = rnd[ACC_W-1:FRAC_W];
      if (zq > (ACC_W-FRAC_W)'(32767)) begin
         z_sat = 16'sh7fff;
      end else if (zq < -(ACC_W-FRAC_W)'(32768)) begin
         z_sat = -16'sh8000;
      end else begin
         z_sat = zq[DATA_W-1:0];
      end
   end

   always_comb begin
      if (cmd.sigmoid) begin
         act_in = sigmoid_q88(z_ff);
      end else begin
         act_in = z_ff[DATA_W-1] ? '0 : z_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= w_q_ff * x_q_ff;
      if (cmd.acc_init) begin
         acc_ff <= {{(ACC_W-DATA_W-FRAC_W){bias_ff[cmd.rd_out][DATA_W-1]}},
                    bias_ff[cmd.rd_out], {FRAC_W{1'b0}}};
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.round) begin
         z_ff <= z_sat;
      end
      if (cmd.load) begin
         neuron_ff <= cmd.rd_out;
         act_ff    <= act_in;
         final_ff  <= cmd.final_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= cmd.issue;
         mul_v_ff <= rd_v_ff;
         if (cmd.load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign stat.pipe_busy = rd_v_ff || mul_v_ff;
   assign stat.out_free  = !out_v_ff || rsp_tready;

   assign rsp_tvalid     = out_v_ff;
   assign rsp_neuron     = neuron_ff;
   assign rsp_activation = act_ff;
   assign rsp_final      = final_ff;

endmodule

// ----- hdl/dense_layer_forward_top.sv -----
// ----------------------------------------------------------------------------
// dense_layer_forward_top
// one dense neural layer in q8.8 with relu or sigmoid output
// ----------------------------------------------------------------------------
// usage
//   req channel: each transfer loads a weight (tuser weight), a bias (tuser
//   bias) or stores one input element (tuser input). an input element with
//   tlast set starts a run over the stored vector.
//   rsp channel: a run gives one transfer per output neuron in neuron order,
//   tlast on the final one.
//   csr port: activation mode, input size and output size; write while idle.
// timing
//   loads do not drop req_tready. a run holds req_tready low until the last
//   result is loaded: one multiply-accumulate unit reads one weight/input
//   pair per cycle from the stores, and each neuron also takes steps for
//   bias load, pipeline drain, rounding and output load.
// reset
//   biases clear to zero, relu, input size 64, output size 16; weight and
//   input stores hold garbage until written.
// stall
//   a result waits in the output register; the next neuron is computed
//   meanwhile and holds until that register is taken.
// ----------------------------------------------------------------------------
module dense_layer_forward_top
   import dlf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // config write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // in_index[5:0], out_index[9:6], value[25:10]
   input  logic [1:0]            req_tuser,   // command
   input  logic                  req_tlast,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // neuron[3:0], activation[19:4]
   output logic                  rsp_tlast
);

   dlf_cmd_type              cmd;
   dlf_stat_type             stat;
   logic [OUT_IDX_W-1:0]     rsp_neuron;
   logic signed [DATA_W-1:0] rsp_activation;

   // sequencer and config registers
   dlf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   // stores and arithmetic, payload fields unpacked from tdata
   dlf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .wr_in_index    (req_tdata[5:0]),
      .wr_out_index   (req_tdata[9:6]),
      .wr_value       (req_tdata[25:10]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_neuron     (rsp_neuron),
      .rsp_activation (rsp_activation),
      .rsp_final      (rsp_tlast)
   );

   // pack the result fields, padded to whole bytes
   assign rsp_tdata = {4'b0000, rsp_activation, rsp_neuron};

endmodule

// ----- hdl/dlf_chk.sv -----
// ----------------------------------------------------------------------------
// dlf_chk
// port-level checks for the dense layer, bound to the top level
// ----------------------------------------------------------------------------
module dlf_chk
   import dlf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [1:0]            req_tuser,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [23:0]           rsp_tdata,
   input logic                  rsp_tlast
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a last input element starts a run, which blocks the request side
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_INPUT && req_tlast |=> !req_tready)
      else $error("request taken during a run");

   // weight and bias loads never start a run
   a_load_stays_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_WEIGHT || req_tuser == CMD_BIAS)
      |=> req_tready)
      else $error("load item dropped ready");

endmodule

bind dense_layer_forward_top dlf_chk u_dlf_chk (.*);
